// ===== rtl/pfs_pkg.sv =====
// Shared constants, codes and types of the parity filter stack.
package pfs_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned MODE_W      = 3;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned FILL_W      = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH      = 3'd0,
    MODE_POP       = 3'd1,
    MODE_PEEK      = 3'd2,
    MODE_DROP_ODD  = 3'd3,
    MODE_DROP_EVEN = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_NOMATCH = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_TOP_RD,
    S_RESULT
  } state_e;

  typedef struct packed {
    status_e                   status;
    logic signed [WORD_W-1:0]  top_value;
    logic        [FILL_W-1:0]  fill_count;
    logic                      is_empty;
  } res_t;

endpackage

// ===== rtl/pfs_if.sv =====
// Valid/ready channel interfaces for operations and results of the stack.
interface pfs_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic signed [31:0] push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink (input valid, input mode, input push_value, output ready);
endinterface

interface pfs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] top_value;
  logic [6:0]         fill_count;
  logic               is_empty;

  modport source (output valid, output status, output top_value, output fill_count,
                  output is_empty, input ready);
  modport sink (input valid, input status, input top_value, input fill_count,
                input is_empty, output ready);
endinterface

// ===== rtl/pfs_engine.sv =====
// Sequencer and entry memory that carry out one stack operation at a time.
module pfs_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  pfs_in_if.sink          req_i,
  output logic            res_valid_o,
  output pfs_pkg::res_t   res_o,
  input  logic            res_take_i
);
  import pfs_pkg::*;

  logic [WORD_W-1:0] entry_mem [STACK_DEPTH];
  logic [WORD_W-1:0] rdata_q;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic               want_q, want_d;
  status_e            status_q, status_d;

  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [CNT_W-1:0]   idx_ext;

  assign idx_ext = CNT_W'(idx_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= entry_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      want_q   <= 1'b0;
      status_q <= STAT_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      want_q   <= want_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    want_d      = want_q;
    status_d    = status_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = rdata_q;
    rd_en       = 1'b0;
    rd_addr     = idx_q;
    req_i.ready = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          status_d = STAT_OK;
          state_d  = S_TOP_RD;
          case (req_i.mode)
            MODE_PUSH: begin
              if (count_q == CNT_W'(STACK_DEPTH)) begin
                status_d = STAT_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(count_q);
                wr_data = req_i.push_value;
                count_d = count_q + CNT_W'(1);
              end
            end
            MODE_POP: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
              end
            end
            MODE_PEEK: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end
            end
            MODE_DROP_ODD, MODE_DROP_EVEN: begin
              if (count_q == '0) begin
                status_d = STAT_EMPTY;
              end else begin
                want_d  = (req_i.mode == MODE_DROP_ODD);
                idx_d   = ADDR_W'(count_q - CNT_W'(1));
                state_d = S_SCAN_RD;
              end
            end
            default: begin
              // Unused mode codes only report the stack as it stands.
              status_d = STAT_OK;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        rd_en   = 1'b1;
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rdata_q[0] == want_q) begin
          if (idx_ext + CNT_W'(1) < count_q) begin
            state_d = S_SHIFT_RD;
          end else begin
            count_d = count_q - CNT_W'(1);
            state_d = S_TOP_RD;
          end
        end else if (idx_q == '0) begin
          status_d = STAT_NOMATCH;
          state_d  = S_TOP_RD;
        end else begin
          idx_d   = idx_q - ADDR_W'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        // Fetch the entry above the gap; it moves down one slot next cycle.
        rd_en   = 1'b1;
        rd_addr = idx_q + ADDR_W'(1);
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        wr_en = 1'b1;
        if (idx_ext + CNT_W'(2) == count_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = S_TOP_RD;
        end else begin
          idx_d   = idx_q + ADDR_W'(1);
          state_d = S_SHIFT_RD;
        end
      end
      S_TOP_RD: begin
        rd_en   = (count_q != '0);
        rd_addr = ADDR_W'(count_q - CNT_W'(1));
        state_d = S_RESULT;
      end
      S_RESULT: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o.status     = status_q;
  assign res_o.top_value  = (count_q == '0) ? '0 : rdata_q;
  assign res_o.fill_count = FILL_W'(count_q);
  assign res_o.is_empty   = (count_q == '0);

endmodule

// ===== rtl/parity_filter_stack.sv =====
// Top level of the parity filter stack: operation channel, engine and result register.
// Push, pop, peek and unused codes: the engine reads the top entry (S_TOP_RD), then holds
// the result (S_RESULT) until the result register takes it; the next operation is accepted in
// the cycle after the result leaves the engine. Odd/even removal: the engine scans from the top,
// reading and checking each entry (S_SCAN_RD, S_SCAN_CHK), then moves each entry above the removed
// one down a slot (S_SHIFT_RD, S_SHIFT_WR) through the one read port. One operation is in the engine at a time.
// Reset clears the fill count and the control state; the entry memory is not cleared.
module parity_filter_stack (
  input  logic       clk_i,
  input  logic       rst_ni,
  pfs_in_if.sink     req_i,
  pfs_out_if.source  rsp_o
);
  import pfs_pkg::*;

  logic res_valid;
  res_t res;
  logic res_take;
  logic out_valid_q, out_valid_d;
  res_t out_q;

  pfs_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  assign res_take = res_valid && (!out_valid_q || rsp_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_take) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.top_value  = out_q.top_value;
  assign rsp_o.fill_count = out_q.fill_count;
  assign rsp_o.is_empty   = out_q.is_empty;

endmodule

// ===== rtl/pfs_checker.sv =====
// Port-level assertions on the parity filter stack, bound to its top level.
module pfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [1:0]  status_i,
  input logic [31:0] top_value_i,
  input logic [6:0]  fill_count_i,
  input logic        is_empty_i
);
  import pfs_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) &&
      $stable(top_value_i) && $stable(fill_count_i) && $stable(is_empty_i))
    else $error("result transaction changed while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (is_empty_i == (fill_count_i == '0)))
    else $error("empty flag disagrees with fill count");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && is_empty_i |-> top_value_i == '0)
    else $error("empty stack reports a nonzero top");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> fill_count_i <= FILL_W'(STACK_DEPTH))
    else $error("fill count above stack depth");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == STAT_FULL |-> fill_count_i == FILL_W'(STACK_DEPTH))
    else $error("full status without a full stack");

endmodule

bind parity_filter_stack pfs_checker u_pfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .top_value_i  (rsp_o.top_value),
  .fill_count_i (rsp_o.fill_count),
  .is_empty_i   (rsp_o.is_empty)
);
